// ----- rtl/core/assert_macros.svh -----
// assertion macros for the rtl, included by the sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// a implies b on the same edge
`define ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// a implies b on the next edge
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/tldq_pkg.sv -----
// shared types and constants for the distance query block
package tldq_pkg;
  localparam int VERT_W = 10;
  localparam int DEPTH_W = 6;
  localparam int TOUR_W = 11;
  localparam int ROW_W = 4;
  localparam int VAL_W = 30;
  localparam int CNT_W = 7;
  localparam int SparseRows = 11;
  localparam int TourLength = 2048;
  localparam int MaxDepth = 64;
  localparam logic [VAL_W-1:0] NO_PATH = 30'd999999999;

  typedef enum logic [2:0] {
    ACT_QUERY = 3'd0, ACT_TOUR = 3'd1, ACT_DEPTH = 3'd2, ACT_SPARSE = 3'd3,
    ACT_LABEL = 3'd4, ACT_HUBPOS = 3'd5, ACT_HUBCNT = 3'd6, ACT_NONE = 3'd7
  } action_t;

  // last member sits in the lowest bits, matching the tdata layout
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [TOUR_W-1:0] slot;
    logic [VERT_W-1:0] other_vertex;
    logic [VERT_W-1:0] vertex;
    logic [2:0] action;
  } item_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_IDLE, CMD_LOAD, CMD_TOUR, CMD_SPAN, CMD_SPARSE, CMD_LCA, CMD_DEPTH,
    CMD_ANC, CMD_HCNT, CMD_HUB, CMD_PAIR, CMD_SUM, CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    logic same;
    logic anc;
    logic loop_done;
    logic clear_done;
  } status_t;
endpackage

// ----- rtl/core/tldq_datapath.sv -----
// stores and arithmetic for the distance query
module tldq_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tldq_pkg::cmd_t                cmd,
  input  tldq_pkg::item_t               item,
  output tldq_pkg::status_t             status,
  output logic [tldq_pkg::VAL_W-1:0]    distance,
  output logic [tldq_pkg::VERT_W-1:0]   lca
);
  import tldq_pkg::*;

  logic [TOUR_W-1:0]  tour_mem [1024];
  logic [DEPTH_W-1:0] depth_mem [1024];
  logic [VERT_W-1:0]  sparse_mem [SparseRows*TourLength];
  logic [VAL_W-1:0]   label_mem [65536];
  logic [DEPTH_W-1:0] hub_mem [65536];
  logic [CNT_W-1:0]   hcnt_mem [1024];
  logic [VERT_W-1:0]  clr_r;

  logic [TOUR_W-1:0] tr_r;
  logic [TOUR_W-1:0] p_r, q_r, qw_r;
  logic [VERT_W-1:0] sl_r, sr_r, lca_r;
  logic [DEPTH_W-1:0] dr_r, dl_r;
  logic [VAL_W-1:0]  lx_r, ly_r, best_r;
  logic [CNT_W-1:0]  n_r, i_r;
  logic [DEPTH_W-1:0] pos_r;
  logic              anc_r, lcax_r;
  logic [TOUR_W-1:0] span;
  logic [TOUR_W-1:0] win;
  logic [ROW_W-1:0]  lvl;
  logic [VAL_W:0]    sum;

  wire [VERT_W-1:0] x = item.vertex;
  wire [VERT_W-1:0] y = item.other_vertex;

  function automatic logic [VERT_W-1:0] sparse_rd(logic [ROW_W-1:0] r, logic [TOUR_W-1:0] s);
    return (r < ROW_W'(SparseRows)) ? sparse_mem[{r, s}] : '0;
  endfunction

  // smallest window with twice its length covering the span:
  // level is the top set bit of q - p
  always_comb begin
    span = q_r - p_r;
    lvl = '0;
    for (int k = 1; k < TOUR_W; k++) begin
      if (span[k]) lvl = ROW_W'(k);
    end
    win = TOUR_W'(1) << lvl;
    sum = {1'b0, lx_r} + {1'b0, ly_r};
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_CLEAR) hcnt_mem[clr_r] <= '0;
    if (cmd == CMD_LOAD) begin
      unique case (action_t'(item.action))
        ACT_TOUR:  tour_mem[x] <= item.value[TOUR_W-1:0];
        ACT_DEPTH: depth_mem[x] <= item.value[DEPTH_W-1:0];
        ACT_SPARSE:
          if (item.row < ROW_W'(SparseRows))
            sparse_mem[{item.row, item.slot}] <= item.value[VERT_W-1:0];
        ACT_LABEL:
          if (item.slot < TOUR_W'(MaxDepth)) label_mem[{x, item.slot[5:0]}] <= item.value;
        ACT_HUBPOS:
          if (item.slot < TOUR_W'(MaxDepth))
            hub_mem[{x, item.slot[5:0]}] <= item.value[DEPTH_W-1:0];
        ACT_HUBCNT:
          hcnt_mem[x] <= (item.value > VAL_W'(MaxDepth)) ? CNT_W'(MaxDepth)
                                                        : item.value[CNT_W-1:0];
        default: ;
      endcase
    end
    case (cmd)
      CMD_TOUR: begin
        tr_r <= tour_mem[x];
        qw_r <= tour_mem[y];
      end
      CMD_SPAN: begin
        p_r <= (tr_r > qw_r) ? qw_r : tr_r;
        q_r <= (tr_r > qw_r) ? tr_r : qw_r;
      end
      CMD_SPARSE: begin
        sl_r <= sparse_rd(lvl, p_r);
        sr_r <= sparse_rd(lvl, q_r - win + 1'b1);
      end
      CMD_LCA: begin
        dl_r <= depth_mem[sl_r];
        dr_r <= depth_mem[sr_r];
      end
      CMD_DEPTH: begin
        lca_r <= (dl_r < dr_r) ? sl_r : sr_r;
        anc_r <= ((dl_r < dr_r) ? sl_r : sr_r) == x || ((dl_r < dr_r) ? sl_r : sr_r) == y;
        lcax_r <= ((dl_r < dr_r) ? sl_r : sr_r) == x;
        dl_r <= depth_mem[((dl_r < dr_r) ? sl_r : sr_r) == x ? x : y];
      end
      CMD_ANC: best_r <= label_mem[{lcax_r ? y : x, dl_r}];
      CMD_HCNT: begin
        n_r <= hcnt_mem[lca_r];
        i_r <= '0;
        best_r <= NO_PATH;
      end
      CMD_HUB: begin
        pos_r <= hub_mem[{lca_r, i_r[5:0]}];
        i_r <= i_r + 1'b1;
      end
      CMD_PAIR: begin
        lx_r <= label_mem[{x, pos_r}];
        ly_r <= label_mem[{y, pos_r}];
      end
      CMD_SUM: if ({1'b0, best_r} > sum) best_r <= sum[VAL_W-1:0];
      default: ;
    endcase
  end

  // hub count clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd == CMD_CLEAR) clr_r <= clr_r + 1'b1;
  end

  assign status.same = (x == y);
  assign status.anc = anc_r;
  assign status.loop_done = (i_r >= n_r);
  assign status.clear_done = (clr_r == '1);
  assign distance = best_r;
  assign lca = lca_r;
endmodule

// ----- rtl/core/tldq_ctrl.sv -----
// sequencer for loads and queries
module tldq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [2:0]          action,
  input  tldq_pkg::status_t   status,
  input  logic                out_tready,
  output logic                busy,
  output logic                out_tvalid,
  output logic                zero_sel,
  output tldq_pkg::cmd_t      cmd
);
  import tldq_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_TOUR, S_SPAN, S_SPARSE, S_LCA, S_DEPTH, S_SEL, S_ANC, S_HCNT,
    S_HUB, S_PAIR, S_SUM, S_OUT, S_CLEAR
  } state_t;
  state_t state_r;
  logic zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      zero_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: if (status.clear_done) state_r <= S_IDLE;
        S_IDLE:
          if (in_fire && action == ACT_QUERY) begin
            zero_r <= status.same;
            state_r <= status.same ? S_OUT : S_TOUR;
          end
        S_TOUR: state_r <= S_SPAN;
        S_SPAN: state_r <= S_SPARSE;
        S_SPARSE: state_r <= S_LCA;
        S_LCA: state_r <= S_DEPTH;
        S_DEPTH: state_r <= S_SEL;
        S_SEL: state_r <= status.anc ? S_ANC : S_HCNT;
        S_ANC: state_r <= S_OUT;
        S_HCNT: state_r <= S_HUB;
        S_HUB: state_r <= status.loop_done ? S_OUT : S_PAIR;
        S_PAIR: state_r <= S_SUM;
        S_SUM: state_r <= S_HUB;
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (state_r)
      S_CLEAR: cmd = CMD_CLEAR;
      S_IDLE: cmd = (in_fire && action != ACT_QUERY) ? CMD_LOAD : CMD_IDLE;
      S_TOUR: cmd = CMD_TOUR;
      S_SPAN: cmd = CMD_SPAN;
      S_SPARSE: cmd = CMD_SPARSE;
      S_LCA: cmd = CMD_LCA;
      S_DEPTH: cmd = CMD_DEPTH;
      S_ANC: cmd = CMD_ANC;
      S_HCNT: cmd = CMD_HCNT;
      S_HUB: cmd = status.loop_done ? CMD_IDLE : CMD_HUB;
      S_PAIR: cmd = CMD_PAIR;
      S_SUM: cmd = CMD_SUM;
      default: cmd = CMD_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign zero_sel = zero_r;

  `ASSERT_IMPL(a_no_accept_busy, in_fire, state_r == S_IDLE)
  `ASSERT_NEXT(a_out_leaves, out_tvalid && out_tready, state_r == S_IDLE)
  `ASSERT_NEXT(a_query_starts, in_fire && action == ACT_QUERY, state_r != S_IDLE)
endmodule

// ----- rtl/core/tree_label_distance_query.sv -----
// top level of the tree label distance query block
// channel | dir | fields
// in_     | in  | tdata: action, vertex, other_vertex, slot, row, value
// out_    | out | tdata: distance, common_ancestor
// a load is taken in the idle state; a query on equal vertices goes straight to output;
// one where a vertex is the ancestor passes tour, span, sparse, lca, depth, select and
// ancestor states; any other hub count, then hub, pair and sum per hub of the ancestor
// (up to 64 hubs); one item is worked at a time; in_tready is low until the result is
// taken; reset is synchronous and active low; after it a pass clears the hub counts
module tree_label_distance_query (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // action, vertex, other_vertex, slot, row, value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // distance, common_ancestor
);
  import tldq_pkg::*;

  item_t item_r, item;
  status_t status;
  cmd_t cmd;
  logic busy, in_fire, zero_sel;
  logic [VAL_W-1:0] query_dist;
  logic [VERT_W-1:0] lca;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign item = in_fire ? item_t'(in_tdata[67:0]) : item_r;

  always_ff @(posedge clk) if (in_fire) item_r <= item_t'(in_tdata[67:0]);

  tldq_ctrl u_ctrl (.clk, .rst_n, .in_fire, .action(item.action), .status, .out_tready,
    .busy, .out_tvalid, .zero_sel, .cmd);
  tldq_datapath u_dp (.clk, .rst_n, .cmd, .item, .status, .distance(query_dist), .lca);

  assign out_tdata = zero_sel ? 40'd0 : {VERT_W'(lca), query_dist};
endmodule
